>>> rtl/core/split_direct_mapped_tlb_assert.svh
// Assertion macros shared by the translation buffer modules.
// Each macro names the assertion, the clock, the reset that disables it,
// the condition, the consequence and the message.
`ifndef SPLIT_DIRECT_MAPPED_TLB_ASSERT_SVH
`define SPLIT_DIRECT_MAPPED_TLB_ASSERT_SVH

// Consequence must hold in the same cycle as the condition.
`define SDTLB_ASSERT_SAME(label, clk, rst, cond, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (cons)) \
    else $error(msg);

// Consequence must hold in the cycle after the condition.
`define SDTLB_ASSERT_NEXT(label, clk, rst, cond, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/core/sdtlb_pkg.sv
// ----------------------------------------------------------------------------
// sdtlb_pkg
// Shared types and constants of the split direct-mapped translation buffer.
// ----------------------------------------------------------------------------
`default_nettype none

package sdtlb_pkg;

  // Fixed field widths of the request and result ports.
  localparam int ADDR_W = 32;
  localparam int DATA_W = 32;
  localparam int SLOT_OUT_W = 6;

  // Default geometry.
  localparam int INSTR_INDEX_BITS_DEF = 6;
  localparam int DATA_INDEX_BITS_DEF = 6;
  localparam int PAGE_SHIFT_DEF = 12;

  // Request operation codes.
  typedef enum logic [1:0] {
    OP_LOOKUP  = 2'd0,
    OP_FILL    = 2'd1,
    OP_INV_SEL = 2'd2,
    OP_INV_ALL = 2'd3
  } op_t;

  // Write commands for one table.
  typedef struct packed {
    logic fill;
    logic clear;
  } tbl_cmd_t;

  // Control of a request on its way from the read stage to the result stage.
  typedef struct packed {
    logic                  valid;
    logic                  lookup;
    logic                  is_data;
    logic [SLOT_OUT_W-1:0] slot;
  } stage_ctrl_t;

endpackage

`default_nettype wire

>>> rtl/core/sdtlb_table.sv
// ----------------------------------------------------------------------------
// sdtlb_table
// One direct-mapped table: valid flops plus page and payload memories with a
// registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module sdtlb_table #(
  parameter int INDEX_BITS = sdtlb_pkg::INSTR_INDEX_BITS_DEF,
  parameter int PAGE_W = sdtlb_pkg::ADDR_W - sdtlb_pkg::PAGE_SHIFT_DEF
) (
  input  wire                           clk,
  input  wire                           rst,
  input  wire sdtlb_pkg::tbl_cmd_t      cmd,
  input  wire [INDEX_BITS-1:0]          index,
  input  wire [PAGE_W-1:0]              wr_page,
  input  wire [sdtlb_pkg::DATA_W-1:0]   wr_payload,
  output logic                          rd_valid,
  output logic [PAGE_W-1:0]             rd_page,
  output logic [sdtlb_pkg::DATA_W-1:0]  rd_payload
);

  localparam int SLOTS = 1 << INDEX_BITS;

  logic [SLOTS-1:0]             valid;
  logic [PAGE_W-1:0]            page_mem [SLOTS];
  logic [sdtlb_pkg::DATA_W-1:0] payload_mem [SLOTS];

  // Valid bits: cleared all at once by reset or invalidate, set by a fill.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid    <= '0;
      rd_valid <= 1'b0;
    end else begin
      rd_valid <= valid[index];
      if (cmd.clear) begin
        valid <= '0;
      end else if (cmd.fill) begin
        valid[index] <= 1'b1;
      end
    end
  end

  // Page and payload memories, read every cycle at the request index.
  always_ff @(posedge clk) begin
    if (cmd.fill) begin
      page_mem[index]    <= wr_page;
      payload_mem[index] <= wr_payload;
    end
    rd_page    <= page_mem[index];
    rd_payload <= payload_mem[index];
  end

endmodule

`default_nettype wire

>>> rtl/core/sdtlb_resp.sv
// ----------------------------------------------------------------------------
// sdtlb_resp
// Page compare on the table read data and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

`include "split_direct_mapped_tlb_assert.svh"

module sdtlb_resp #(
  parameter int PAGE_W = sdtlb_pkg::ADDR_W - sdtlb_pkg::PAGE_SHIFT_DEF
) (
  input  wire                                clk,
  input  wire                                rst,
  input  wire sdtlb_pkg::stage_ctrl_t        ctrl,
  input  wire [PAGE_W-1:0]                   req_page,
  input  wire                                i_valid,
  input  wire [PAGE_W-1:0]                   i_page,
  input  wire [sdtlb_pkg::DATA_W-1:0]        i_payload,
  input  wire                                d_valid,
  input  wire [PAGE_W-1:0]                   d_page,
  input  wire [sdtlb_pkg::DATA_W-1:0]        d_payload,
  output logic                               done,
  output logic                               hit,
  output logic [sdtlb_pkg::DATA_W-1:0]       found_data,
  output logic [sdtlb_pkg::SLOT_OUT_W-1:0]   slot_index
);

  logic                         sel_valid;
  logic [PAGE_W-1:0]            sel_page;
  logic [sdtlb_pkg::DATA_W-1:0] sel_payload;
  logic                         hit_next;

  // Select the addressed table and compare the stored page.
  always_comb begin
    sel_valid   = ctrl.is_data ? d_valid : i_valid;
    sel_page    = ctrl.is_data ? d_page : i_page;
    sel_payload = ctrl.is_data ? d_payload : i_payload;
    hit_next    = ctrl.valid && ctrl.lookup && sel_valid && (sel_page == req_page);
  end

  // Result register; the strobe and hit flag are reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
      hit  <= 1'b0;
    end else begin
      done <= ctrl.valid;
      hit  <= hit_next;
    end
    found_data <= hit_next ? sel_payload : '0;
    slot_index <= ctrl.slot;
  end

  `SDTLB_ASSERT_SAME(a_hit_only_with_done, clk, rst, hit, done, "hit without result strobe")
  `SDTLB_ASSERT_SAME(a_miss_data_zero, clk, rst, done && !hit, found_data == '0, "data on a miss")

endmodule

`default_nettype wire

>>> rtl/core/split_direct_mapped_tlb.sv
// ----------------------------------------------------------------------------
// split_direct_mapped_tlb
// Split instruction and data direct-mapped translation buffers.
// ----------------------------------------------------------------------------
// A request is taken on any cycle with start high and busy low; busy is high
// only while rst is asserted, so one request a cycle is accepted. Every
// request gives exactly one result, through the registered table read and
// then the page compare into the result register. The result is on the
// ports for one cycle with done high and cannot be held off. Fills and
// invalidates take effect at their accept edge, so a lookup in the very next
// cycle already sees them.
// ----------------------------------------------------------------------------
`default_nettype none

`include "split_direct_mapped_tlb_assert.svh"

module split_direct_mapped_tlb #(
  parameter int INSTR_INDEX_BITS = sdtlb_pkg::INSTR_INDEX_BITS_DEF,
  parameter int DATA_INDEX_BITS  = sdtlb_pkg::DATA_INDEX_BITS_DEF,
  parameter int PAGE_SHIFT       = sdtlb_pkg::PAGE_SHIFT_DEF
) (
  input  wire                               clk,
  input  wire                               rst,
  input  wire                               start,
  output logic                              busy,
  input  wire [1:0]                         operation,
  input  wire                               table_select,
  input  wire [sdtlb_pkg::ADDR_W-1:0]       virtual_address,
  input  wire [sdtlb_pkg::DATA_W-1:0]       entry_data,
  output logic                              done,
  output logic                              hit,
  output logic [sdtlb_pkg::DATA_W-1:0]      found_data,
  output logic [sdtlb_pkg::SLOT_OUT_W-1:0]  slot_index
);

  localparam int PAGE_W = sdtlb_pkg::ADDR_W - PAGE_SHIFT;
  localparam logic [sdtlb_pkg::ADDR_W-1:0] IMASK =
    (sdtlb_pkg::ADDR_W'(1) << INSTR_INDEX_BITS) - sdtlb_pkg::ADDR_W'(1);
  localparam logic [sdtlb_pkg::ADDR_W-1:0] DMASK =
    (sdtlb_pkg::ADDR_W'(1) << DATA_INDEX_BITS) - sdtlb_pkg::ADDR_W'(1);

  logic                          accept;
  sdtlb_pkg::op_t                op;
  logic [sdtlb_pkg::ADDR_W-1:0]  vp;
  logic [PAGE_W-1:0]             page;
  logic [sdtlb_pkg::ADDR_W-1:0]  slot_wide;
  logic                          is_inv;
  sdtlb_pkg::tbl_cmd_t           i_cmd;
  sdtlb_pkg::tbl_cmd_t           d_cmd;
  sdtlb_pkg::stage_ctrl_t        ctrl_next;
  sdtlb_pkg::stage_ctrl_t        ctrl;
  logic [PAGE_W-1:0]             req_page;

  logic                          i_rd_valid;
  logic [PAGE_W-1:0]             i_rd_page;
  logic [sdtlb_pkg::DATA_W-1:0]  i_rd_payload;
  logic                          d_rd_valid;
  logic [PAGE_W-1:0]             d_rd_page;
  logic [sdtlb_pkg::DATA_W-1:0]  d_rd_payload;

  assign busy   = rst;
  assign accept = start && !busy;

  // Decode the request into table commands and stage control.
  always_comb begin
    op        = sdtlb_pkg::op_t'(operation);
    vp        = virtual_address >> PAGE_SHIFT;
    page      = vp[PAGE_W-1:0];
    slot_wide = table_select ? (vp & DMASK) : (vp & IMASK);
    is_inv    = (op == sdtlb_pkg::OP_INV_SEL) || (op == sdtlb_pkg::OP_INV_ALL);

    i_cmd.fill  = accept && (op == sdtlb_pkg::OP_FILL) && !table_select;
    i_cmd.clear = accept && ((op == sdtlb_pkg::OP_INV_ALL) ||
                             ((op == sdtlb_pkg::OP_INV_SEL) && !table_select));
    d_cmd.fill  = accept && (op == sdtlb_pkg::OP_FILL) && table_select;
    d_cmd.clear = accept && ((op == sdtlb_pkg::OP_INV_ALL) ||
                             ((op == sdtlb_pkg::OP_INV_SEL) && table_select));

    ctrl_next.valid   = accept;
    ctrl_next.lookup  = (op == sdtlb_pkg::OP_LOOKUP);
    ctrl_next.is_data = table_select;
    ctrl_next.slot    = is_inv ? '0 : slot_wide[sdtlb_pkg::SLOT_OUT_W-1:0];
  end

  // Request register alongside the table read.
  always_ff @(posedge clk) begin
    if (rst) begin
      ctrl.valid <= 1'b0;
    end else begin
      ctrl.valid <= ctrl_next.valid;
    end
    ctrl.lookup  <= ctrl_next.lookup;
    ctrl.is_data <= ctrl_next.is_data;
    ctrl.slot    <= ctrl_next.slot;
    req_page     <= page;
  end

  sdtlb_table #(
    .INDEX_BITS (INSTR_INDEX_BITS),
    .PAGE_W     (PAGE_W)
  ) u_instr_table (
    .clk        (clk),
    .rst        (rst),
    .cmd        (i_cmd),
    .index      (vp[INSTR_INDEX_BITS-1:0]),
    .wr_page    (page),
    .wr_payload (entry_data),
    .rd_valid   (i_rd_valid),
    .rd_page    (i_rd_page),
    .rd_payload (i_rd_payload)
  );

  sdtlb_table #(
    .INDEX_BITS (DATA_INDEX_BITS),
    .PAGE_W     (PAGE_W)
  ) u_data_table (
    .clk        (clk),
    .rst        (rst),
    .cmd        (d_cmd),
    .index      (vp[DATA_INDEX_BITS-1:0]),
    .wr_page    (page),
    .wr_payload (entry_data),
    .rd_valid   (d_rd_valid),
    .rd_page    (d_rd_page),
    .rd_payload (d_rd_payload)
  );

  sdtlb_resp #(
    .PAGE_W (PAGE_W)
  ) u_resp (
    .clk        (clk),
    .rst        (rst),
    .ctrl       (ctrl),
    .req_page   (req_page),
    .i_valid    (i_rd_valid),
    .i_page     (i_rd_page),
    .i_payload  (i_rd_payload),
    .d_valid    (d_rd_valid),
    .d_page     (d_rd_page),
    .d_payload  (d_rd_payload),
    .done       (done),
    .hit        (hit),
    .found_data (found_data),
    .slot_index (slot_index)
  );

  `SDTLB_ASSERT_NEXT(a_accept_gives_result, clk, rst, accept, ##1 done, "request without result")
  `SDTLB_ASSERT_NEXT(a_no_spurious_result, clk, rst, !accept, ##1 !done, "result without request")
  `SDTLB_ASSERT_NEXT(a_inv_slot_zero, clk, rst, accept && is_inv, ##1 (slot_index == '0), "invalidate slot not zero")

endmodule

`default_nettype wire
